/* sv/icv6_pkg.sv */
package icv6_pkg;

	localparam int unsigned MAX_MSG_LEN = 1500;

	localparam logic [15:0] MSG_LEN_LIMIT     = 16'(MAX_MSG_LEN);
	localparam logic [15:0] NEXT_HDR_ICMPV6   = 16'd58;
	localparam logic [15:0] ECHO_REPLY_WORD   = 16'h8100;
	localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
	localparam logic [15:0] MIN_MSG_LEN       = 16'd4;
	localparam logic [10:0] REPLY_MAX_LEN_RST = 11'd1400;
	localparam logic [4:0]  ADDR_BYTES        = 5'd16;

	localparam logic [7:0] TYPE_ECHO_REQ    = 8'd128;
	localparam logic [7:0] TYPE_RTR_SOLICIT = 8'd133;
	localparam logic [7:0] TYPE_RTR_ADVERT  = 8'd134;
	localparam logic [7:0] TYPE_NBR_SOLICIT = 8'd135;
	localparam logic [7:0] TYPE_NBR_ADVERT  = 8'd136;

	typedef enum logic [1:0] {
		MODE_REQ_SRC,
		MODE_REQ_DST,
		MODE_REPLY_SRC,
		MODE_MSG
	} mode_t;

	typedef enum logic [2:0] {
		ACT_DROP,
		ACT_ECHO_REPLY,
		ACT_NBR_SOLICIT,
		ACT_NBR_ADVERT,
		ACT_RTR_SOLICIT,
		ACT_RTR_ADVERT
	} action_t;

	typedef enum logic [2:0] {
		RSN_NONE,
		RSN_SHORT,
		RSN_BAD_CSUM,
		RSN_REPLY_LEN,
		RSN_TYPE
	} reason_t;

	// partially folded ones-complement sum, never above 0x10001
	typedef logic [16:0] ocsum_t;

	// message totals handed from the accumulator to the finishing stages
	typedef struct packed {
		ocsum_t      req_addr_sum;
		ocsum_t      reply_src_sum;
		ocsum_t      body_sum;
		logic [15:0] byte_count;
		logic [15:0] type_code_word;
		logic [15:0] rx_csum_word;
	} snap_t;

	function automatic ocsum_t oc_add(ocsum_t s, logic [15:0] w);
		logic [17:0] t;
		t = {1'b0, s} + {2'b00, w};
		oc_add = 17'({2'b00, t[15:0]} + {16'b0, t[17:16]});
	endfunction

	function automatic logic [15:0] oc_fold(ocsum_t s);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {16'b0, s[16]};
		oc_fold = t[15:0] + {15'b0, t[16]};
	endfunction

endpackage

/* sv/icv6_ifs.sv */
interface icv6_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] data_byte;
	logic       last;

	modport source(output valid, mode, data_byte, last, input ready);
	modport sink(input valid, mode, data_byte, last, output ready);
endinterface

interface icv6_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [2:0]  drop_reason;
	logic [7:0]  msg_type;
	logic [15:0] received_checksum;
	logic [15:0] computed_checksum;
	logic [15:0] reply_checksum;
	logic [15:0] msg_length;

	modport source(
		output valid, action, drop_reason, msg_type, received_checksum,
			computed_checksum, reply_checksum, msg_length,
		input ready
	);
	modport sink(
		input valid, action, drop_reason, msg_type, received_checksum,
			computed_checksum, reply_checksum, msg_length,
		output ready
	);
endinterface

/* sv/icv6_accum.sv */
module icv6_accum (
	input  logic            clk,
	input  logic            arst_n,
	icv6_in_if.sink         in_item,
	output logic            snap_valid,
	input  logic            snap_ready,
	output icv6_pkg::snap_t snap
);

	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	icv6_pkg::ocsum_t ras_q, rss_q, body_q;
	icv6_pkg::ocsum_t ras_n, rss_n, body_n;
	logic [15:0] count_q, tcw_q, rxw_q;
	logic [15:0] count_n, tcw_n, rxw_n;
	logic [4:0]  idx_q [3];
	logic [4:0]  idx_n [3];

	logic        is_msg, last_msg, fire;
	logic [4:0]  idx_cur;
	logic [15:0] word;

	assign is_msg   = icv6_pkg::mode_t'(mode_s1) == icv6_pkg::MODE_MSG;
	assign last_msg = valid_s1 && is_msg && last_s1;
	// only the final byte of a message has to wait for room downstream
	assign fire     = valid_s1 && (!last_msg || snap_ready);
	assign in_item.ready = !valid_s1 || fire;

	always_comb begin
		ras_n   = ras_q;
		rss_n   = rss_q;
		body_n  = body_q;
		count_n = count_q;
		tcw_n   = tcw_q;
		rxw_n   = rxw_q;
		for (int k = 0; k < 3; k++) begin
			idx_n[k] = idx_q[k];
		end
		idx_cur = 5'd0;
		word    = 16'd0;
		if (!is_msg) begin
			for (int k = 0; k < 3; k++) begin
				if (mode_s1 == 2'(k)) begin
					idx_cur = idx_q[k];
				end
			end
			word = idx_cur[0] ? {8'h00, byte_s1} : {byte_s1, 8'h00};
			if (idx_cur < icv6_pkg::ADDR_BYTES) begin
				for (int k = 0; k < 3; k++) begin
					if (mode_s1 == 2'(k)) begin
						idx_n[k] = idx_cur + 5'd1;
					end
				end
				unique case (icv6_pkg::mode_t'(mode_s1))
					icv6_pkg::MODE_REQ_SRC: begin
						ras_n = icv6_pkg::oc_add(ras_q, word);
						rss_n = icv6_pkg::oc_add(rss_q, word);
					end
					icv6_pkg::MODE_REQ_DST: begin
						ras_n = icv6_pkg::oc_add(ras_q, word);
					end
					icv6_pkg::MODE_REPLY_SRC: begin
						rss_n = icv6_pkg::oc_add(rss_q, word);
					end
					default: begin
					end
				endcase
			end
		end else begin
			word = count_q[0] ? {8'h00, byte_s1} : {byte_s1, 8'h00};
			if (count_q < icv6_pkg::MSG_LEN_LIMIT) begin
				priority if (count_q == 16'd0) begin
					tcw_n = {byte_s1, tcw_q[7:0]};
				end else if (count_q == 16'd1) begin
					tcw_n = {tcw_q[15:8], byte_s1};
				end else if (count_q == 16'd2) begin
					rxw_n = {byte_s1, rxw_q[7:0]};
				end else if (count_q == 16'd3) begin
					rxw_n = {rxw_q[15:8], byte_s1};
				end else begin
					body_n = icv6_pkg::oc_add(body_q, word);
				end
			end
			if (count_q != icv6_pkg::COUNT_MAX) begin
				count_n = count_q + 16'd1;
			end
		end
	end

	assign snap_valid          = last_msg;
	assign snap.req_addr_sum   = ras_n;
	assign snap.reply_src_sum  = rss_n;
	assign snap.body_sum       = body_n;
	assign snap.byte_count     = count_n;
	assign snap.type_code_word = tcw_n;
	assign snap.rx_csum_word   = rxw_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_item.ready) begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			mode_s1 <= in_item.mode;
			byte_s1 <= in_item.data_byte;
			last_s1 <= in_item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ras_q   <= '0;
			rss_q   <= '0;
			body_q  <= '0;
			count_q <= '0;
			tcw_q   <= '0;
			rxw_q   <= '0;
			for (int k = 0; k < 3; k++) begin
				idx_q[k] <= '0;
			end
		end else if (fire) begin
			if (last_msg) begin
				ras_q   <= '0;
				rss_q   <= '0;
				body_q  <= '0;
				count_q <= '0;
				tcw_q   <= '0;
				rxw_q   <= '0;
				for (int k = 0; k < 3; k++) begin
					idx_q[k] <= '0;
				end
			end else begin
				ras_q   <= ras_n;
				rss_q   <= rss_n;
				body_q  <= body_n;
				count_q <= count_n;
				tcw_q   <= tcw_n;
				rxw_q   <= rxw_n;
				for (int k = 0; k < 3; k++) begin
					idx_q[k] <= idx_n[k];
				end
			end
		end
	end

endmodule

/* sv/icv6_finish.sv */
module icv6_finish (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            snap_valid,
	output logic            snap_ready,
	input  icv6_pkg::snap_t snap,
	input  logic [10:0]     reply_max_len,
	icv6_out_if.source      out_item
);

	typedef struct packed {
		icv6_pkg::ocsum_t sum_part;
		icv6_pkg::ocsum_t reply_part;
		logic [15:0]      body_fold;
		logic [15:0]      type_code_word;
		logic [15:0]      rx_csum_word;
		logic [15:0]      byte_count;
	} part_t;

	logic            valid_s2, valid_s3;
	icv6_pkg::snap_t snap_s2;
	part_t           part_s3, part_n;

	logic out_adv, s3_free, s2_free;

	assign out_adv    = !out_item.valid || out_item.ready;
	assign s3_free    = !valid_s3 || out_adv;
	assign s2_free    = !valid_s2 || s3_free;
	assign snap_ready = s2_free;

	// pseudo-header: length (truncated for the check), next header
	logic [15:0] sum_len;
	always_comb begin
		sum_len = (snap_s2.byte_count < icv6_pkg::MSG_LEN_LIMIT) ?
			snap_s2.byte_count : icv6_pkg::MSG_LEN_LIMIT;
		part_n.sum_part = icv6_pkg::oc_add(
			icv6_pkg::oc_add(snap_s2.req_addr_sum, sum_len), icv6_pkg::NEXT_HDR_ICMPV6);
		part_n.reply_part = icv6_pkg::oc_add(
			icv6_pkg::oc_add(snap_s2.reply_src_sum, snap_s2.byte_count),
			icv6_pkg::NEXT_HDR_ICMPV6);
		part_n.body_fold      = icv6_pkg::oc_fold(snap_s2.body_sum);
		part_n.type_code_word = snap_s2.type_code_word;
		part_n.rx_csum_word   = snap_s2.rx_csum_word;
		part_n.byte_count     = snap_s2.byte_count;
	end

	logic [15:0]       computed, reply;
	logic [7:0]        msg_type;
	icv6_pkg::action_t action;
	icv6_pkg::reason_t reason;

	always_comb begin
		computed = ~icv6_pkg::oc_fold(icv6_pkg::oc_add(
			icv6_pkg::oc_add(part_s3.sum_part, part_s3.type_code_word), part_s3.body_fold));
		reply = ~icv6_pkg::oc_fold(icv6_pkg::oc_add(
			icv6_pkg::oc_add(part_s3.reply_part, icv6_pkg::ECHO_REPLY_WORD),
			part_s3.body_fold));
		msg_type = part_s3.type_code_word[15:8];
		action   = icv6_pkg::ACT_DROP;
		reason   = icv6_pkg::RSN_NONE;
		priority if (part_s3.byte_count < icv6_pkg::MIN_MSG_LEN) begin
			reason = icv6_pkg::RSN_SHORT;
		end else if (computed != part_s3.rx_csum_word) begin
			reason = icv6_pkg::RSN_BAD_CSUM;
		end else if (msg_type == icv6_pkg::TYPE_ECHO_REQ) begin
			if (part_s3.byte_count > {5'b0, reply_max_len} ||
				part_s3.byte_count > icv6_pkg::MSG_LEN_LIMIT) begin
				reason = icv6_pkg::RSN_REPLY_LEN;
			end else begin
				action = icv6_pkg::ACT_ECHO_REPLY;
			end
		end else if (msg_type == icv6_pkg::TYPE_NBR_SOLICIT) begin
			action = icv6_pkg::ACT_NBR_SOLICIT;
		end else if (msg_type == icv6_pkg::TYPE_NBR_ADVERT) begin
			action = icv6_pkg::ACT_NBR_ADVERT;
		end else if (msg_type == icv6_pkg::TYPE_RTR_SOLICIT) begin
			action = icv6_pkg::ACT_RTR_SOLICIT;
		end else if (msg_type == icv6_pkg::TYPE_RTR_ADVERT) begin
			action = icv6_pkg::ACT_RTR_ADVERT;
		end else begin
			reason = icv6_pkg::RSN_TYPE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			out_item.valid <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= snap_valid;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
			if (out_adv) begin
				out_item.valid <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && s2_free) begin
			snap_s2 <= snap;
		end
		if (valid_s2 && s3_free) begin
			part_s3 <= part_n;
		end
		if (valid_s3 && out_adv) begin
			out_item.action            <= action;
			out_item.drop_reason       <= reason;
			out_item.msg_type          <= msg_type;
			out_item.received_checksum <= part_s3.rx_csum_word;
			out_item.computed_checksum <= computed;
			out_item.reply_checksum    <=
				(action == icv6_pkg::ACT_ECHO_REPLY) ? reply : 16'd0;
			out_item.msg_length        <= part_s3.byte_count;
		end
	end

endmodule

/* sv/icmpv6_rx_check_and_dispatch.sv */
// ICMPv6 receive check and dispatch. Feed the request source and destination
// addresses, the chosen reply source address (mode 0, 1, 2; 16 bytes each,
// most significant first) and the message bytes (mode 3, last on the final
// byte), one byte per item; the block takes one item every clock cycle while
// input is not held off. The per-byte ones-complement accumulate-and-fold sits
// between the input register and the running sums, so it sets that rate. Each
// message gives one result item after its final byte is accepted, the checksum
// and type checks being spread over two more stages and an output
// register. Input is held off only when a result waits at the output and the
// finishing stages are full. reply_max_len (reset 1400) may only be written
// while no message is in flight.
module icmpv6_rx_check_and_dispatch (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	icv6_in_if.sink     in_item,
	icv6_out_if.source  out_item
);

	logic [10:0]     reply_max_len_q;
	logic            snap_valid, snap_ready;
	icv6_pkg::snap_t snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_max_len_q <= icv6_pkg::REPLY_MAX_LEN_RST;
		end else if (cfg_we) begin
			reply_max_len_q <= cfg_wdata;
		end
	end

	icv6_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.snap      (snap)
	);

	icv6_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap),
		.reply_max_len(reply_max_len_q),
		.out_item     (out_item)
	);

endmodule

/* sv/icv6_checker.sv */
module icv6_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  action,
	input logic [2:0]  drop_reason,
	input logic [15:0] reply_checksum,
	input logic [15:0] msg_length
);

	// a held result keeps its decision
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(drop_reason))
		else $error("result changed while stalled");

	a_echo_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == icv6_pkg::ACT_ECHO_REPLY |-> drop_reason == icv6_pkg::RSN_NONE)
		else $error("echo reply with a drop reason");

	a_reason_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drop_reason != icv6_pkg::RSN_NONE |-> action == icv6_pkg::ACT_DROP)
		else $error("drop reason without drop");

	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != icv6_pkg::ACT_ECHO_REPLY |-> reply_checksum == 16'd0)
		else $error("reply checksum on non-echo result");

	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drop_reason == icv6_pkg::RSN_SHORT |-> msg_length < icv6_pkg::MIN_MSG_LEN)
		else $error("short drop on long message");

endmodule

bind icmpv6_rx_check_and_dispatch icv6_checker u_icv6_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_item.valid),
	.out_ready     (out_item.ready),
	.action        (out_item.action),
	.drop_reason   (out_item.drop_reason),
	.reply_checksum(out_item.reply_checksum),
	.msg_length    (out_item.msg_length)
);

/* test/testbench.sv */
module testbench;
	import icv6_pkg::*;

	typedef struct packed {
		action_t     action;
		reason_t     reason;
		logic [7:0]  msg_type;
		logic [15:0] rx_csum;
		logic [15:0] calc_csum;
		logic [15:0] reply_csum;
		logic [15:0] length;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;

	icv6_in_if  in_if ();
	icv6_out_if out_if ();

	icmpv6_rx_check_and_dispatch u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_item  (in_if),
		.out_item (out_if)
	);

	always #5 clk = ~clk;

	// checksum state mirrored from the block, reset values
	logic [10:0]  max_reply_len = REPLY_MAX_LEN_RST;
	int unsigned  pseudo_sum = 0;
	int unsigned  echo_pseudo_sum = 0;
	int unsigned  body_acc = 0;
	int unsigned  msg_count = 0;
	logic [15:0]  type_code = '0;
	logic [15:0]  rx_word = '0;
	int unsigned  addr_seen [3] = '{0, 0, 0};

	verdict_t     verdict_q [$];
	verdict_t     want;
	int unsigned  mismatches = 0;
	int unsigned  counted_items = 0;
	int unsigned  predicted_results = 0;
	int unsigned  echo_seen = 0;
	int unsigned  ndp_seen = 0;
	int unsigned  drop_seen = 0;
	int unsigned  cfg_writes = 0;

	// sender pacing
	int unsigned  burst_left = 0;
	bit           steady = 1'b0;

	// receiver pacing
	bit           hold_toggle = 1'b0;
	bit           hold_seen = 1'b0;
	int unsigned  hold_left = 0;
	logic [6:0]   rx_tick = '0;
	logic [1:0]   rx_style = '0;

	function automatic int unsigned csum_acc(input int unsigned acc, input int unsigned word);
		int unsigned t;
		t = acc + (word & 32'hFFFF);
		t = (t & 32'hFFFF) + (t >> 16);
		return t & 32'h1FFFF;
	endfunction

	function automatic logic [15:0] csum_fold(input int unsigned acc);
		int unsigned t;
		t = (acc & 32'hFFFF) + (acc >> 16);
		t = (t & 32'hFFFF) + (t >> 16);
		return t[15:0];
	endfunction

	function automatic bit predict_item(input mode_t m, input logic [7:0] b, input logic lst,
			output verdict_t v);
		int unsigned w, pos, n, s, r;
		logic [15:0] calc;
		logic [7:0]  typ;
		v = '0;
		if (m != MODE_MSG) begin
			if (addr_seen[int'(m)] >= 16) return 0;
			w = addr_seen[int'(m)][0] ? {8'h00, b} : {b, 8'h00};
			addr_seen[int'(m)]++;
			case (m)
				MODE_REQ_SRC: begin
					pseudo_sum = csum_acc(pseudo_sum, w);
					echo_pseudo_sum = csum_acc(echo_pseudo_sum, w);
				end
				MODE_REQ_DST: pseudo_sum = csum_acc(pseudo_sum, w);
				default: echo_pseudo_sum = csum_acc(echo_pseudo_sum, w);
			endcase
			return 0;
		end
		pos = msg_count;
		if (pos < MAX_MSG_LEN) begin
			case (pos)
				0: type_code[15:8] = b;
				1: type_code[7:0] = b;
				2: rx_word[15:8] = b;
				3: rx_word[7:0] = b;
				default: body_acc = csum_acc(body_acc, pos[0] ? {8'h00, b} : {b, 8'h00});
			endcase
		end
		if (msg_count < 32'hFFFF) msg_count++;
		if (!lst) return 0;

		// truncated length goes into the pseudo-header
		n = msg_count < MAX_MSG_LEN ? msg_count : MAX_MSG_LEN;
		s = csum_acc(pseudo_sum, n);
		s = csum_acc(s, NEXT_HDR_ICMPV6);
		s = csum_acc(s, type_code);
		s = csum_acc(s, csum_fold(body_acc));
		calc = ~csum_fold(s);
		typ = type_code[15:8];
		v.msg_type = typ;
		v.rx_csum = rx_word;
		v.calc_csum = calc;
		v.length = msg_count[15:0];
		v.action = ACT_DROP;
		v.reason = RSN_NONE;
		if (msg_count < 4)
			v.reason = RSN_SHORT;
		else if (calc != rx_word)
			v.reason = RSN_BAD_CSUM;
		else begin
			case (typ)
				TYPE_ECHO_REQ: begin
					if (msg_count > max_reply_len || msg_count > MAX_MSG_LEN)
						v.reason = RSN_REPLY_LEN;
					else begin
						r = csum_acc(echo_pseudo_sum, msg_count);
						r = csum_acc(r, NEXT_HDR_ICMPV6);
						r = csum_acc(r, ECHO_REPLY_WORD);
						r = csum_acc(r, csum_fold(body_acc));
						v.reply_csum = ~csum_fold(r);
						v.action = ACT_ECHO_REPLY;
					end
				end
				TYPE_NBR_SOLICIT: v.action = ACT_NBR_SOLICIT;
				TYPE_NBR_ADVERT:  v.action = ACT_NBR_ADVERT;
				TYPE_RTR_SOLICIT: v.action = ACT_RTR_SOLICIT;
				TYPE_RTR_ADVERT:  v.action = ACT_RTR_ADVERT;
				default:          v.reason = RSN_TYPE;
			endcase
		end
		pseudo_sum = 0;
		echo_pseudo_sum = 0;
		body_acc = 0;
		msg_count = 0;
		type_code = '0;
		rx_word = '0;
		addr_seen = '{0, 0, 0};
		return 1;
	endfunction

	task automatic send_item(input mode_t m, input logic [7:0] b, input logic lst);
		verdict_t v;
		if (!steady && burst_left == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
		in_if.valid     <= 1'b1;
		in_if.mode      <= m;
		in_if.data_byte <= b;
		in_if.last      <= lst;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		if (burst_left != 0) burst_left--;
		if (m == MODE_MSG || addr_seen[int'(m)] < 16) counted_items++;
		if (predict_item(m, b, lst, v)) begin
			verdict_q.push_back(v);
			predicted_results++;
		end
	endtask

	// addresses in random interleaving, then the message with its checksum field
	// filled in (or corrupted). fill: 0 random, 1 all ones, 2 all zeros
	task automatic send_message(input logic [7:0] mtype, input int unsigned len,
			input bit good, input int unsigned n_src, input int unsigned n_dst,
			input int unsigned n_rsrc, input int unsigned fill, input bit extras);
		logic [7:0]  addr [3][16];
		logic [7:0]  msg [$];
		int unsigned cnt [3];
		int unsigned left [3];
		int unsigned k, i, n, acc;
		logic [15:0] csum;
		logic [7:0]  b;
		cnt[0] = n_src;
		cnt[1] = n_dst;
		cnt[2] = n_rsrc;
		for (k = 0; k < 3; k++) begin
			left[k] = cnt[k];
			for (i = 0; i < 16; i++)
				addr[k][i] = fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom);
		end
		while (left[0] + left[1] + left[2] != 0) begin
			k = $urandom_range(0, 2);
			if (left[k] != 0) begin
				// last on an address byte must be ignored
				send_item(mode_t'(k), addr[k][cnt[k] - left[k]], $urandom_range(0, 15) == 0);
				left[k]--;
			end
		end
		if (extras) begin
			for (k = 0; k < 3; k++)
				if (cnt[k] == 16)
					repeat ($urandom_range(1, 3))
						send_item(mode_t'(k), 8'($urandom), 1'($urandom));
		end

		n = len < MAX_MSG_LEN ? len : MAX_MSG_LEN;
		for (i = 0; i < n; i++) begin
			case (i)
				0: b = mtype;
				1: b = 8'($urandom);
				default: b = fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom);
			endcase
			msg.push_back(b);
		end
		acc = n + 58;
		for (k = 0; k < 2; k++)
			for (i = 0; i < cnt[k]; i++)
				acc += i[0] ? {8'h00, addr[k][i]} : {addr[k][i], 8'h00};
		for (i = 0; i < n; i++)
			if (i != 2 && i != 3)
				acc += i[0] ? {8'h00, msg[i]} : {msg[i], 8'h00};
		acc = (acc & 32'hFFFF) + (acc >> 16);
		acc = (acc & 32'hFFFF) + (acc >> 16);
		csum = ~acc[15:0];
		if (!good) csum ^= 16'($urandom_range(1, 65535));
		if (n > 2) msg[2] = csum[15:8];
		if (n > 3) msg[3] = csum[7:0];
		for (i = 0; i < len; i++)
			send_item(MODE_MSG, i < n ? msg[i] : 8'($urandom), i == len - 1);
	endtask

	task automatic settle;
		int unsigned waited;
		in_if.valid <= 1'b0;
		burst_left = 0;
		waited = 0;
		while (verdict_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [10:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_reply_len = value;
		cfg_writes++;
	endtask

	task automatic test_directed_types;
		send_message(8'hFF, 1, 1'b1, 0, 0, 0, 0, 1'b0);
		send_message(TYPE_ECHO_REQ, 3, 1'b1, 0, 0, 0, 0, 1'b0);
		send_message(TYPE_ECHO_REQ, 4, 1'b1, 0, 0, 0, 1, 1'b0);
		send_message(8'd129, 4, 1'b1, 0, 0, 0, 0, 1'b0);
		send_message(TYPE_NBR_SOLICIT, 4, 1'b1, 0, 0, 0, 2, 1'b0);
		send_message(TYPE_NBR_ADVERT, 4, 1'b1, 0, 0, 0, 0, 1'b0);
		send_message(TYPE_RTR_SOLICIT, 4, 1'b1, 0, 0, 0, 0, 1'b0);
		send_message(TYPE_RTR_ADVERT, 4, 1'b0, 0, 0, 0, 0, 1'b0);
	endtask

	task automatic test_reply_limits;
		write_cfg(11'd4);
		send_message(TYPE_ECHO_REQ, 4, 1'b1, 16, 16, 16, 1, 1'b1);
		send_message(TYPE_ECHO_REQ, 5, 1'b1, 16, 16, 16, 2, 1'b1);
		write_cfg(11'd40);
		send_message(TYPE_ECHO_REQ, 40, 1'b1, 16, 16, 16, 1, 1'b0);
		send_message(TYPE_ECHO_REQ, 41, 1'b1, 16, 16, 16, 0, 1'b0);
		write_cfg(11'd2047);
		send_message(TYPE_ECHO_REQ, 64, 1'b1, 16, 16, 16, 0, 1'b0);
		send_message(TYPE_NBR_ADVERT, 60, 1'b1, 16, 16, 0, 0, 1'b0);
	endtask

	task automatic test_backpressure;
		settle();
		steady = 1'b1;
		hold_toggle = ~hold_toggle;
		repeat (60) send_message(TYPE_NBR_SOLICIT, 4, 1'b1, 0, 0, 0, 0, 1'b0);
		steady = 1'b0;
	endtask

	task automatic test_random_traffic;
		int unsigned msgs, r, len, ns, nd, nr, fill;
		logic [7:0]  mtype;
		msgs = 0;
		while (counted_items < 1450) begin
			if (msgs % 12 == 11) begin
				case ($urandom_range(0, 5))
					0: write_cfg(11'd4);
					1: write_cfg(11'd1500);
					2: write_cfg(11'd2047);
					3: write_cfg(REPLY_MAX_LEN_RST);
					4: write_cfg(11'($urandom_range(4, 2047)));
					default: write_cfg(11'($urandom_range(4, 64)));
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 35) mtype = TYPE_ECHO_REQ;
			else if (r < 45) mtype = 8'd129;
			else if (r < 55) mtype = TYPE_NBR_SOLICIT;
			else if (r < 63) mtype = TYPE_NBR_ADVERT;
			else if (r < 70) mtype = TYPE_RTR_SOLICIT;
			else if (r < 77) mtype = TYPE_RTR_ADVERT;
			else mtype = 8'($urandom);
			r = $urandom_range(0, 99);
			if (r < 8) len = $urandom_range(1, 3);
			else if (r < 80) len = $urandom_range(4, 40);
			else if (r < 95) len = $urandom_range(41, 200);
			else len = $urandom_range(201, 600);
			r = $urandom_range(0, 3);
			if (r < 2) begin
				ns = 16; nd = 16; nr = 16;
			end else if (r == 2) begin
				ns = 0; nd = 0; nr = 0;
			end else begin
				ns = $urandom_range(0, 16);
				nd = $urandom_range(0, 16);
				nr = $urandom_range(0, 16);
			end
			r = $urandom_range(0, 19);
			fill = r < 2 ? 1 : r < 3 ? 2 : 0;
			send_message(mtype, len, $urandom_range(0, 99) < 85, ns, nd, nr, fill,
				$urandom_range(0, 99) < 15);
			msgs++;
		end
	endtask

	// receiver: long hold on request, otherwise a style picked each time the 7-bit tick counter wraps
	always @(posedge clk) begin
		if (hold_seen != hold_toggle) begin
			hold_seen    <= hold_toggle;
			hold_left    <= 400;
			out_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			out_if.ready <= 1'b0;
		end else begin
			if (rx_tick == 0) rx_style <= 2'($urandom_range(0, 3));
			rx_tick <= rx_tick + 1'b1;
			case (rx_style)
				2'd0: out_if.ready <= 1'b1;
				2'd1: out_if.ready <= 1'($urandom_range(0, 1));
				2'd2: out_if.ready <= $urandom_range(0, 4) == 0;
				default: out_if.ready <= rx_tick[2];
			endcase
		end
	end

	task automatic check_field(input string what, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
			if (verdict_q.size() == 0) begin
				$display("%0t unexpected result item: action %0d length %0d", $time,
					out_if.action, out_if.msg_length);
				mismatches++;
			end else begin
				want = verdict_q.pop_front();
				check_field("action", want.action, out_if.action);
				check_field("drop_reason", want.reason, out_if.drop_reason);
				check_field("msg_type", want.msg_type, out_if.msg_type);
				check_field("received_checksum", want.rx_csum, out_if.received_checksum);
				check_field("computed_checksum", want.calc_csum, out_if.computed_checksum);
				check_field("reply_checksum", want.reply_csum, out_if.reply_checksum);
				check_field("msg_length", want.length, out_if.msg_length);
				if (want.action == ACT_ECHO_REPLY) echo_seen++;
				else if (want.action == ACT_DROP) drop_seen++;
				else ndp_seen++;
			end
		end
	end

	initial begin
		#50_000_000;
		$display("FAIL icmpv6_rx_check_and_dispatch");
		$finish;
	end

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		in_if.valid     <= 1'b0;
		in_if.mode      <= MODE_REQ_SRC;
		in_if.data_byte <= '0;
		in_if.last      <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_types();
		test_reply_limits();
		test_backpressure();
		test_random_traffic();

		settle();
		if (verdict_q.size() != 0) begin
			$display("%0t %0d results expected, actual none; first: action %0d length %0d",
				$time, verdict_q.size(), verdict_q[0].action, verdict_q[0].length);
			mismatches += verdict_q.size();
		end
		$display("Sent %0d counted items over %0d reply length settings; %0d results checked",
			counted_items, cfg_writes + 1, echo_seen + ndp_seen + drop_seen);
		$display("  echo replies %0d, ndp handoffs %0d, drops %0d",
			echo_seen, ndp_seen, drop_seen);
		if (mismatches == 0)
			$display("PASS icmpv6_rx_check_and_dispatch");
		else
			$display("FAIL icmpv6_rx_check_and_dispatch");
		$finish;
	end

endmodule

/* icmpv6_rx_check_and_dispatch.f */
sv/icv6_pkg.sv
sv/icv6_ifs.sv
sv/icv6_accum.sv
sv/icv6_finish.sv
sv/icmpv6_rx_check_and_dispatch.sv
sv/icv6_checker.sv
test/testbench.sv
